[sv/scc_pkg.sv]
// Package for the system control coprocessor register block.
// Holds instruction field positions, register selector codes and the result type.
// No dependencies; imported by every other file of the block.
package scc_pkg;

  localparam int unsigned DataW = 32;

  // Instruction field positions
  localparam int unsigned LoadBit   = 20;
  localparam int unsigned CrnHi     = 19;
  localparam int unsigned CrnLo     = 16;
  localparam int unsigned RdHi      = 15;
  localparam int unsigned RdLo      = 12;
  localparam int unsigned Op2Hi     = 7;
  localparam int unsigned Op2Lo     = 5;
  localparam int unsigned CrmHi     = 3;
  localparam int unsigned CrmLo     = 0;

  // Control register bits
  localparam int unsigned CompatBit  = 15;
  localparam int unsigned HighVecBit = 13;

  // CRn selector codes
  localparam logic [3:0] CRN_ID      = 4'd0;
  localparam logic [3:0] CRN_CONTROL = 4'd1;
  localparam logic [3:0] CRN_TTB     = 4'd2;
  localparam logic [3:0] CRN_DOMAIN  = 4'd3;
  localparam logic [3:0] CRN_FSR     = 4'd5;
  localparam logic [3:0] CRN_FAR     = 4'd6;
  localparam logic [3:0] CRN_CACHE   = 4'd7;
  localparam logic [3:0] CRN_TLB     = 4'd8;
  localparam logic [3:0] CRN_PID     = 4'd13;

  // CRm and op2 codes for maintenance operations
  localparam logic [3:0] CRM_ICACHE   = 4'd5;
  localparam logic [3:0] CRM_DTLB     = 4'd6;
  localparam logic [3:0] CRM_UNIFIED  = 4'd7;
  localparam logic [3:0] CRM_TEST_D   = 4'd10;
  localparam logic [3:0] CRM_TEST_ID  = 4'd14;
  localparam logic [2:0] OP2_TEST     = 3'd3;

  // Register index that is never written by a read
  localparam logic [3:0] RD_PC = 4'd15;

  typedef struct packed {
    logic             rd_write;
    logic [3:0]       rd_index;
    logic [DataW-1:0] rd_data;
    logic             vector_high;
    logic             control_write;
    logic [DataW-1:0] control_value;
    logic             flush_code;
    logic             tlb_invalidate;
    logic             flags_from_zero;
    logic             error;
  } scc_result_t;

endpackage

[sv/scc_in_if.sv]
// Input channel of the coprocessor register block: one instruction word per handshake.
// Depends on scc_pkg for the data width.
interface scc_in_if import scc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] instr;
  logic [DataW-1:0] rd_value;

  modport source (output valid, output instr, output rd_value, input ready);
  modport sink   (input valid, input instr, input rd_value, output ready);
endinterface

[sv/scc_out_if.sv]
// Result channel of the coprocessor register block: one result word per handshake.
// Depends on scc_pkg for the data width.
interface scc_out_if import scc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             rd_write;
  logic [3:0]       rd_index;
  logic [DataW-1:0] rd_data;
  logic             vector_high;
  logic             control_write;
  logic [DataW-1:0] control_value;
  logic             flush_code;
  logic             tlb_invalidate;
  logic             flags_from_zero;
  logic             error;

  modport source (output valid, output rd_write, output rd_index, output rd_data,
                  output vector_high, output control_write, output control_value,
                  output flush_code, output tlb_invalidate, output flags_from_zero,
                  output error, input ready);
  modport sink   (input valid, input rd_write, input rd_index, input rd_data,
                  input vector_high, input control_write, input control_value,
                  input flush_code, input tlb_invalidate, input flags_from_zero,
                  input error, output ready);
endinterface

[sv/scc_core.sv]
// Decoder and register file of the coprocessor register block.
// Computes one result from the staged instruction and updates state on advance.
// Depends on scc_pkg.
module scc_core import scc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [DataW-1:0] cfg_wdata,
  input  logic             adv,
  input  logic [DataW-1:0] instr,
  input  logic [DataW-1:0] rd_value,
  output scc_result_t      res
);

  logic [DataW-1:0] id_r, control_r, ttb_r, domain_r, fsr_r, far_r, pid_r;
  logic [DataW-1:0] control_nxt, ttb_nxt, domain_nxt, fsr_nxt, far_nxt, pid_nxt;
  logic [3:0]       crn, crm, rd;
  logic [2:0]       op2;
  logic             load;
  logic [DataW-1:0] val;
  logic             ctl_wr, flush, tlb, nz, err, wr_rd;

  assign crn  = instr[CrnHi:CrnLo];
  assign crm  = instr[CrmHi:CrmLo];
  assign rd   = instr[RdHi:RdLo];
  assign op2  = instr[Op2Hi:Op2Lo];
  assign load = instr[LoadBit];

  always_comb begin
    val         = '0;
    ctl_wr      = 1'b0;
    flush       = 1'b0;
    tlb         = 1'b0;
    nz          = 1'b0;
    err         = 1'b0;
    control_nxt = control_r;
    ttb_nxt     = ttb_r;
    domain_nxt  = domain_r;
    fsr_nxt     = fsr_r;
    far_nxt     = far_r;
    pid_nxt     = pid_r;
    if (load) begin
      unique case (crn)
        CRN_ID:      val = id_r;
        CRN_CONTROL: val = control_r;
        CRN_TTB:     val = ttb_r;
        CRN_DOMAIN:  val = domain_r;
        CRN_FSR:     val = fsr_r;
        CRN_FAR:     val = far_r;
        CRN_PID:     val = pid_r;
        CRN_CACHE:   nz  = (crm == CRM_TEST_D || crm == CRM_TEST_ID) && op2 == OP2_TEST;
        default:     val = '0;
      endcase
    end else begin
      unique case (crn)
        CRN_CONTROL: begin
          if (rd_value[CompatBit]) begin
            err = 1'b1;
          end else begin
            control_nxt = rd_value;
            ctl_wr      = 1'b1;
          end
        end
        CRN_TTB:    ttb_nxt    = rd_value;
        CRN_DOMAIN: domain_nxt = rd_value;
        CRN_FSR:    fsr_nxt    = rd_value;
        CRN_FAR:    far_nxt    = rd_value;
        CRN_PID:    pid_nxt    = rd_value;
        CRN_CACHE:  flush      = (crm == CRM_ICACHE || crm == CRM_UNIFIED);
        CRN_TLB: begin
          flush = (crm == CRM_ICACHE || crm == CRM_UNIFIED);
          tlb   = (crm == CRM_ICACHE || crm == CRM_UNIFIED || crm == CRM_DTLB);
        end
        default: ;
      endcase
    end
  end

  assign wr_rd = load && (rd != RD_PC);

  always_comb begin
    res.rd_write        = wr_rd;
    res.rd_index        = rd;
    res.rd_data         = wr_rd ? val : '0;
    res.vector_high     = control_nxt[HighVecBit];
    res.control_write   = ctl_wr;
    res.control_value   = control_nxt;
    res.flush_code      = flush;
    res.tlb_invalidate  = tlb;
    res.flags_from_zero = nz;
    res.error           = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r      <= '0;
      control_r <= '0;
      ttb_r     <= '0;
      domain_r  <= '0;
      fsr_r     <= '0;
      far_r     <= '0;
      pid_r     <= '0;
    end else begin
      if (cfg_we) begin
        id_r <= cfg_wdata;
      end
      if (adv) begin
        control_r <= control_nxt;
        ttb_r     <= ttb_nxt;
        domain_r  <= domain_nxt;
        fsr_r     <= fsr_nxt;
        far_r     <= far_nxt;
        pid_r     <= pid_nxt;
      end
    end
  end

  // Bit 15 may never reach the control register
  a_no_compat: assert property (@(posedge clk) disable iff (!rst_n)
    !control_r[CompatBit])
    else $error("control register holds backwards compatible bit");

  // Control register only changes on an accepted control write
  a_ctl_change: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && res.control_write) |=> $stable(control_r))
    else $error("control register changed without a control write");

endmodule

[sv/system_control_coprocessor_regs.sv]
// Top level of the system control coprocessor register block.
// Stages input and result words around scc_core; depends on scc_pkg,
// scc_in_if, scc_out_if and scc_core.

// Takes one register-transfer instruction word with the value of its core
// register Rd and returns one result word per instruction. Throughput is one
// word per cycle unless the receiver stalls; the input and result registers
// bracket the decode and register-file logic. The control, translation-base,
// domain, fault-status, fault-address and process-id registers update in
// instruction order as each word leaves the input register. Writing
// cfg_wdata with cfg_we high sets the value returned for reads of the
// identification register. Reads into register 15 write no core register;
// a control write with bit 15 set is rejected with error.
module system_control_coprocessor_regs import scc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [DataW-1:0] cfg_wdata,
  scc_in_if.sink           in_ch,
  scc_out_if.source        out_ch
);

  logic             stg_valid_r;
  logic [DataW-1:0] stg_instr_r, stg_rd_value_r;
  logic             out_valid_r;
  scc_result_t      out_res_r;
  scc_result_t      res;
  logic             adv;

  // Advance the staged word when the result register is empty or draining
  assign adv         = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || adv;

  // Input register: load on accept, drop the valid bit once advanced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_instr_r    <= in_ch.instr;
      stg_rd_value_r <= in_ch.rd_value;
    end
  end

  scc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .instr     (stg_instr_r),
    .rd_value  (stg_rd_value_r),
    .res       (res)
  );

  // Result register: hold while stalled, load when the staged word advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.rd_write        = out_res_r.rd_write;
  assign out_ch.rd_index        = out_res_r.rd_index;
  assign out_ch.rd_data         = out_res_r.rd_data;
  assign out_ch.vector_high     = out_res_r.vector_high;
  assign out_ch.control_write   = out_res_r.control_write;
  assign out_ch.control_value   = out_res_r.control_value;
  assign out_ch.flush_code      = out_res_r.flush_code;
  assign out_ch.tlb_invalidate  = out_res_r.tlb_invalidate;
  assign out_ch.flags_from_zero = out_res_r.flags_from_zero;
  assign out_ch.error           = out_res_r.error;

  // A rejected control write never reports a control update
  a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.error && out_res_r.control_write))
    else $error("error and control_write both set");

  // Register 15 is never written by a read
  a_no_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.rd_index == RD_PC) |-> !out_res_r.rd_write)
    else $error("read wrote register 15");

  // No core write means zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.rd_write) |-> (out_res_r.rd_data == '0))
    else $error("rd_data nonzero without rd_write");

  // Vector base follows control bit 13
  a_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.vector_high == out_res_r.control_value[HighVecBit]))
    else $error("vector_high disagrees with control value");

endmodule

[tb/sv/tb_system_control_coprocessor_regs.sv]
// Self-checking testbench for system_control_coprocessor_regs.
// Drives coprocessor transfer words through the scc_in_if / scc_out_if channels and
// checks every result word against a local predictor; depends on scc_pkg and both interfaces.
module tb_system_control_coprocessor_regs import scc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Direction of a register transfer, carried in the load bit
  typedef enum bit {XFER_WRITE = 1'b0, XFER_READ = 1'b1} xfer_dir_t;

  // A CRn that the block does not implement
  localparam logic [3:0] CRN_UNUSED = 4'd4;

  localparam int unsigned DirRows        = 25;
  localparam int unsigned WordsPerPhase  = 438;
  localparam int unsigned IdPhases       = 4;
  localparam int unsigned CycleLimit     = 200_000;
  localparam int unsigned TailCycles     = 4;

  // One row of the directed sequence. Where pinned is set, rd_data and error
  // are known up front and override the predictor for that word.
  typedef struct {
    logic [DataW-1:0] instr;
    logic [DataW-1:0] rd_value;
    bit               pinned;
    logic [DataW-1:0] pin_data;
    bit               pin_err;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [DataW-1:0] cfg_wdata;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  system_control_coprocessor_regs DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the coprocessor state, advanced word by word as the block accepts them
  logic [DataW-1:0] id_shadow  = '0;
  logic [DataW-1:0] ctl_shadow = '0;
  logic [DataW-1:0] ttb_shadow = '0;
  logic [DataW-1:0] dom_shadow = '0;
  logic [DataW-1:0] fsr_shadow = '0;
  logic [DataW-1:0] far_shadow = '0;
  logic [DataW-1:0] pid_shadow = '0;

  scc_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  logic [7:0] stall_tick = '0;
  logic [1:0] stall_mode = '0;

  step_row_t dir_rows [DirRows];
  logic [DataW-1:0] id_settings [IdPhases];

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop in case the block hangs or drops a handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Build a register transfer word around the usual MCR/MRC encoding for coprocessor 15
  function automatic logic [DataW-1:0] make_instr(xfer_dir_t dir, logic [3:0] crn,
                                                  logic [3:0] rd, logic [3:0] crm,
                                                  logic [2:0] op2);
    logic [DataW-1:0] w;
    w = 32'hEE00_0F10;
    w[LoadBit]     = dir;
    w[CrnHi:CrnLo] = crn;
    w[RdHi:RdLo]   = rd;
    w[CrmHi:CrmLo] = crm;
    w[Op2Hi:Op2Lo] = op2;
    return w;
  endfunction

  // Execute one transfer on the shadow state and return the result word it produces
  function automatic scc_result_t scc_execute(logic [DataW-1:0] w, logic [DataW-1:0] src);
    scc_result_t r;
    logic [3:0] crn;
    logic [3:0] crm;
    logic [2:0] op2;
    logic [DataW-1:0] val;
    crn = w[CrnHi:CrnLo];
    crm = w[CrmHi:CrmLo];
    op2 = w[Op2Hi:Op2Lo];
    val = '0;
    r = '0;
    r.rd_index = w[RdHi:RdLo];
    if (w[LoadBit]) begin
      case (crn)
        CRN_ID:      val = id_shadow;
        CRN_CONTROL: val = ctl_shadow;
        CRN_TTB:     val = ttb_shadow;
        CRN_DOMAIN:  val = dom_shadow;
        CRN_FSR:     val = fsr_shadow;
        CRN_FAR:     val = far_shadow;
        CRN_PID:     val = pid_shadow;
        // test and clean: reads zero, flags come from zero
        CRN_CACHE:   r.flags_from_zero = (crm == CRM_TEST_D || crm == CRM_TEST_ID) &&
                                         op2 == OP2_TEST;
        default:     val = '0;
      endcase
      // a read aimed at the PC writes no core register
      if (r.rd_index != RD_PC) begin
        r.rd_write = 1'b1;
        r.rd_data  = val;
      end
    end else begin
      case (crn)
        CRN_CONTROL: begin
          if (src[CompatBit]) begin
            r.error = 1'b1;
          end else begin
            ctl_shadow      = src;
            r.control_write = 1'b1;
          end
        end
        CRN_TTB:    ttb_shadow = src;
        CRN_DOMAIN: dom_shadow = src;
        CRN_FSR:    fsr_shadow = src;
        CRN_FAR:    far_shadow = src;
        CRN_PID:    pid_shadow = src;
        CRN_CACHE:  r.flush_code = (crm == CRM_ICACHE || crm == CRM_UNIFIED);
        CRN_TLB: begin
          r.flush_code     = (crm == CRM_ICACHE || crm == CRM_UNIFIED);
          r.tlb_invalidate = (crm == CRM_ICACHE || crm == CRM_UNIFIED || crm == CRM_DTLB);
        end
        default: ;
      endcase
    end
    r.control_value = ctl_shadow;
    r.vector_high   = ctl_shadow[HighVecBit];
    return r;
  endfunction

  // Random transfer word: mostly well-formed selectors with random filler, some pure noise
  function automatic logic [DataW-1:0] pick_instr();
    logic [DataW-1:0] w;
    logic [3:0] crn;
    logic [3:0] crm;
    w = $urandom;
    if ($urandom_range(0, 9) == 0) return w;
    case ($urandom_range(0, 9))
      0:       crn = CRN_ID;
      1, 2:    crn = CRN_CONTROL;
      3:       crn = CRN_TTB;
      4:       crn = CRN_DOMAIN;
      5:       crn = CRN_FSR;
      6:       crn = CRN_FAR;
      7:       crn = CRN_CACHE;
      8:       crn = CRN_TLB;
      default: crn = ($urandom_range(0, 1) != 0) ? CRN_PID : 4'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       crm = CRM_ICACHE;
      1:       crm = CRM_DTLB;
      2:       crm = CRM_UNIFIED;
      3:       crm = CRM_TEST_D;
      4:       crm = CRM_TEST_ID;
      default: crm = 4'($urandom);
    endcase
    w[CrnHi:CrnLo] = crn;
    w[CrmHi:CrmLo] = crm;
    if ($urandom_range(0, 1) != 0) w[Op2Hi:Op2Lo] = OP2_TEST;
    if ($urandom_range(0, 5) == 0) w[RdHi:RdLo] = RD_PC;
    return w;
  endfunction

  // Present one word and hold it until accepted; the sender runs in bursts with gaps
  task automatic send_word(input logic [DataW-1:0] w, input logic [DataW-1:0] src);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) :
                                                 $urandom_range(1, 24);
    end
    in_ch.valid    <= 1'b1;
    in_ch.instr    <= w;
    in_ch.rd_value <= src;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid and hold until every expected result word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Load the identification value; only called while the block is idle
  task automatic load_id(input logic [DataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    id_shadow = v;
    cfg_we    <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [DataW-1:0] want,
                                      logic [DataW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Receiver stalls: the pattern is picked anew whenever stall_tick[6:0] wraps to zero,
  // among always ready, mostly ready, mostly stalled and a rhythm set by stall_tick[2]
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[6:0] == 7'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= stall_tick[2];
    endcase
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    scc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with none expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("rd_write", DataW'(want.rd_write), DataW'(out_ch.rd_write));
        check_field("rd_index", DataW'(want.rd_index), DataW'(out_ch.rd_index));
        check_field("rd_data", want.rd_data, out_ch.rd_data);
        check_field("vector_high", DataW'(want.vector_high), DataW'(out_ch.vector_high));
        check_field("control_write", DataW'(want.control_write),
                    DataW'(out_ch.control_write));
        check_field("control_value", want.control_value, out_ch.control_value);
        check_field("flush_code", DataW'(want.flush_code), DataW'(out_ch.flush_code));
        check_field("tlb_invalidate", DataW'(want.tlb_invalidate),
                    DataW'(out_ch.tlb_invalidate));
        check_field("flags_from_zero", DataW'(want.flags_from_zero),
                    DataW'(out_ch.flags_from_zero));
        check_field("error", DataW'(want.error), DataW'(out_ch.error));
      end
    end
  end

  initial begin : stimulus
    scc_result_t r;
    logic [DataW-1:0] src;

    in_ch.valid    <= 1'b0;
    in_ch.instr    <= '0;
    in_ch.rd_value <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;

    // Directed sequence. Fields: word, Rd value, pinned, pinned rd_data, pinned error.
    // Runs with the identification value still at its reset value.
    dir_rows = '{
      // reset values read back as zero
      '{make_instr(XFER_READ,  CRN_ID,      4'd0, 4'd0, 3'd0), 32'h0,         1'b1, 32'h0, 1'b0},
      '{make_instr(XFER_READ,  CRN_CONTROL, 4'd1, 4'd0, 3'd0), 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
      // control write with every bit but the compatibility bit, then read back
      '{make_instr(XFER_WRITE, CRN_CONTROL, 4'd2, 4'd0, 3'd0), 32'hFFFF_7FFF, 1'b1, 32'h0, 1'b0},
      '{make_instr(XFER_READ,  CRN_CONTROL, 4'd3, 4'd0, 3'd0), 32'h0,
        1'b1, 32'hFFFF_7FFF, 1'b0},
      // compatibility bit set: rejected, control keeps its value
      '{make_instr(XFER_WRITE, CRN_CONTROL, 4'd4, 4'd0, 3'd0), 32'h0000_8000, 1'b1, 32'h0, 1'b1},
      '{make_instr(XFER_READ,  CRN_CONTROL, 4'd5, 4'd0, 3'd0), 32'h0,
        1'b1, 32'hFFFF_7FFF, 1'b0},
      // high vectors alone
      '{make_instr(XFER_WRITE, CRN_CONTROL, 4'd6, 4'd0, 3'd0), 32'h0000_2000, 1'b0, 32'h0, 1'b0},
      // load the remaining registers
      '{make_instr(XFER_WRITE, CRN_TTB,     4'd7, 4'd0, 3'd0), 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{make_instr(XFER_WRITE, CRN_DOMAIN,  4'd8, 4'd0, 3'd0), 32'h5555_5555, 1'b0, 32'h0, 1'b0},
      '{make_instr(XFER_WRITE, CRN_FSR,     4'd9, 4'd0, 3'd0), 32'h0000_00FF, 1'b0, 32'h0, 1'b0},
      '{make_instr(XFER_WRITE, CRN_FAR,     4'd10, 4'd0, 3'd0), 32'h8000_0001, 1'b0, 32'h0, 1'b0},
      '{make_instr(XFER_WRITE, CRN_PID,     4'd11, 4'd0, 3'd0), 32'hFE00_0000, 1'b0, 32'h0, 1'b0},
      '{make_instr(XFER_READ,  CRN_TTB,     4'd9, 4'd0, 3'd0), 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{make_instr(XFER_READ,  CRN_DOMAIN,  4'd10, 4'd0, 3'd0), 32'h0, 1'b1, 32'h5555_5555, 1'b0},
      '{make_instr(XFER_READ,  CRN_FSR,     4'd11, 4'd0, 3'd0), 32'h0, 1'b1, 32'h0000_00FF, 1'b0},
      '{make_instr(XFER_READ,  CRN_FAR,     4'd12, 4'd0, 3'd0), 32'h0, 1'b1, 32'h8000_0001, 1'b0},
      // read into the PC is suppressed
      '{make_instr(XFER_READ,  CRN_PID,     RD_PC, 4'd0, 3'd0), 32'h0, 1'b1, 32'h0, 1'b0},
      '{make_instr(XFER_READ,  CRN_PID,     4'd14, 4'd0, 3'd0), 32'h0, 1'b1, 32'hFE00_0000, 1'b0},
      // test and clean, into the PC and into a normal register
      '{make_instr(XFER_READ,  CRN_CACHE,   RD_PC, CRM_TEST_D, OP2_TEST), 32'h0,
        1'b1, 32'h0, 1'b0},
      '{make_instr(XFER_READ,  CRN_CACHE,   4'd0, CRM_TEST_ID, OP2_TEST), 32'hFFFF_FFFF,
        1'b1, 32'h0, 1'b0},
      // cache and TLB maintenance
      '{make_instr(XFER_WRITE, CRN_CACHE,   4'd0, CRM_ICACHE, 3'd0), 32'h0, 1'b0, 32'h0, 1'b0},
      '{make_instr(XFER_WRITE, CRN_TLB,     4'd0, CRM_UNIFIED, 3'd0), 32'h0, 1'b0, 32'h0, 1'b0},
      '{make_instr(XFER_WRITE, CRN_TLB,     4'd0, CRM_DTLB, 3'd0), 32'h0, 1'b0, 32'h0, 1'b0},
      // TLB reads and unimplemented registers return zero
      '{make_instr(XFER_READ,  CRN_TLB,     4'd13, CRM_UNIFIED, 3'd0), 32'h0, 1'b1, 32'h0, 1'b0},
      '{make_instr(XFER_READ,  CRN_UNUSED,  4'd1, 4'd0, 3'd0), 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0}
    };

    // Hold reset, then release it for good
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].instr, dir_rows[i].rd_value);
      r = scc_execute(dir_rows[i].instr, dir_rows[i].rd_value);
      if (dir_rows[i].pinned) begin
        r.rd_data = dir_rows[i].pin_data;
        r.error   = dir_rows[i].pin_err;
      end
      pending_results.push_back(r);
    end

    // Random part, one phase per identification value, extremes included
    id_settings[0] = 32'hFFFF_FFFF;
    id_settings[1] = 32'h0;
    id_settings[2] = 32'h8000_0001;
    id_settings[3] = $urandom;

    foreach (id_settings[p]) begin
      // the block must be idle before the value changes
      drain();
      load_id(id_settings[p]);
      repeat (WordsPerPhase) begin
        src = $urandom;
        // keep most control writes legal so the register actually moves
        if ($urandom_range(0, 3) != 0) src[CompatBit] = 1'b0;
        send_word(pick_instr(), src);
        pending_results.push_back(scc_execute(in_ch.instr, in_ch.rd_value));
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    // Let the last words come back, then keep watching for stray result words
    drain();
    repeat (TailCycles) @(posedge clk);

    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
sv/scc_pkg.sv
sv/scc_in_if.sv
sv/scc_out_if.sv
sv/scc_core.sv
sv/system_control_coprocessor_regs.sv
tb/sv/tb_system_control_coprocessor_regs.sv
